[rtl/cau_pkg.sv]
// shared types and constants for the complex arithmetic unit
package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // information that rides along the divider chain next to the quotient lanes
    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic [15:0] res_re;
        logic [15:0] res_im;
        logic        ovf;
    } t_side;

endpackage

[rtl/cau_front.sv]
// product and sum stages ahead of the divider chain
module cau_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    output logic               o_valid,
    output logic [1:0]         o_mode,
    output logic signed [32:0] o_num_re,
    output logic signed [32:0] o_num_im,
    output logic [31:0]        o_den,
    output logic signed [16:0] o_sum_re,
    output logic signed [16:0] o_sum_im
);
    import cau_pkg::*;

    logic               r_va;
    logic [1:0]         r_mode_a;
    logic signed [31:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic signed [16:0] r_sum_re_a, r_sum_im_a;
    logic signed [16:0] n_sum_re, n_sum_im;

    always_comb begin
        if (i_mode == MODE_SUB) begin
            n_sum_re = 17'(i_a_re) - 17'(i_b_re);
            n_sum_im = 17'(i_a_im) - 17'(i_b_im);
        end else begin
            n_sum_re = 17'(i_a_re) + 17'(i_b_re);
            n_sum_im = 17'(i_a_im) + 17'(i_b_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_va    <= i_valid;
            o_valid <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode_a   <= i_mode;
            r_p_rr     <= i_a_re * i_b_re;
            r_p_ii     <= i_a_im * i_b_im;
            r_p_ri     <= i_a_re * i_b_im;
            r_p_ir     <= i_a_im * i_b_re;
            r_p_bb     <= i_b_re * i_b_re;
            r_p_cc     <= i_b_im * i_b_im;
            r_sum_re_a <= n_sum_re;
            r_sum_im_a <= n_sum_im;

            o_mode   <= r_mode_a;
            o_sum_re <= r_sum_re_a;
            o_sum_im <= r_sum_im_a;
            o_den    <= 32'($unsigned(r_p_bb)) + 32'($unsigned(r_p_cc));
            if (r_mode_a == MODE_DIV) begin
                o_num_re <= 33'(r_p_rr) + 33'(r_p_ii);
                o_num_im <= 33'(r_p_ir) - 33'(r_p_ri);
            end else begin
                o_num_re <= 33'(r_p_rr) - 33'(r_p_ii);
                o_num_im <= 33'(r_p_ri) + 33'(r_p_ir);
            end
        end
    end

endmodule

[rtl/cau_div_cell.sv]
// one restoring-division cell: one quotient bit per lane, registered
module cau_div_cell #(
    parameter int NUM_W = 41
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  cau_pkg::t_side       i_side,
    input  logic [32:0]          i_den,
    input  logic [32:0]          i_rem_re,
    input  logic [32:0]          i_rem_im,
    input  logic [NUM_W-1:0]     i_num_re,
    input  logic [NUM_W-1:0]     i_num_im,
    input  logic [NUM_W-1:0]     i_quo_re,
    input  logic [NUM_W-1:0]     i_quo_im,
    output logic                 o_valid,
    output cau_pkg::t_side       o_side,
    output logic [32:0]          o_den,
    output logic [32:0]          o_rem_re,
    output logic [32:0]          o_rem_im,
    output logic [NUM_W-1:0]     o_num_re,
    output logic [NUM_W-1:0]     o_num_im,
    output logic [NUM_W-1:0]     o_quo_re,
    output logic [NUM_W-1:0]     o_quo_im
);
    import cau_pkg::*;

    logic [33:0] w_t_re, w_t_im, w_d;
    logic        w_ge_re, w_ge_im;
    logic [33:0] w_r_re, w_r_im;

    always_comb begin
        w_d     = {1'b0, i_den};
        w_t_re  = {i_rem_re, i_num_re[NUM_W-1]};
        w_t_im  = {i_rem_im, i_num_im[NUM_W-1]};
        w_ge_re = w_t_re >= w_d;
        w_ge_im = w_t_im >= w_d;
        w_r_re  = w_ge_re ? (w_t_re - w_d) : w_t_re;
        w_r_im  = w_ge_im ? (w_t_im - w_d) : w_t_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side   <= i_side;
            o_den    <= i_den;
            o_rem_re <= w_r_re[32:0];
            o_rem_im <= w_r_im[32:0];
            o_num_re <= {i_num_re[NUM_W-2:0], 1'b0};
            o_num_im <= {i_num_im[NUM_W-2:0], 1'b0};
            o_quo_re <= {i_quo_re[NUM_W-2:0], w_ge_re};
            o_quo_im <= {i_quo_im[NUM_W-2:0], w_ge_im};
        end
    end

endmodule

[rtl/complex_arithmetic_unit_core.sv]
// top level of the complex arithmetic unit: add, subtract, multiply, divide
//
// Input channel: i_valid, o_stall and the operand ports i_mode, i_a_re, i_a_im,
// i_b_re, i_b_im; a transfer happens on a clock edge with i_valid high and
// o_stall low. Output channel: o_valid, i_stall and o_res_re, o_res_im,
// o_overflow, o_divide_by_zero; a transfer happens with o_valid high and
// i_stall low. Every input transfer gives exactly one result, in order.
// The pipeline is two product and sum stages, one operand preparation stage,
// a chain of FRAC_BITS + 33 divider cells that each resolve one quotient bit,
// and an output register. Throughput is one item per cycle while i_stall
// does not hold the pipeline. All modes go down the same pipeline, so
// results leave in order whatever the mode mix.
// While a result waits with i_stall high, the whole pipeline holds and
// o_stall is raised; otherwise a new item is taken in every cycle.
// Synchronous active-low reset empties the pipeline; no state is kept
// between items.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_res_re,
    output logic signed [15:0] o_res_im,
    output logic               o_overflow,
    output logic               o_divide_by_zero
);
    import cau_pkg::*;

    localparam int          NUM_W = 33 + FRAC_BITS;
    localparam logic [32:0] HALF  = 33'((1 << FRAC_BITS) >> 1);

    function automatic logic [16:0] sat_mag(input logic neg, input logic [NUM_W-1:0] mag);
        logic       o;
        logic [15:0] v;
        if (neg) begin
            o = mag > NUM_W'(32768);
            v = o ? 16'h8000 : (~mag[15:0] + 16'd1);
        end else begin
            o = mag > NUM_W'(32767);
            v = o ? 16'h7fff : mag[15:0];
        end
        return {o, v};
    endfunction

    function automatic logic [16:0] sat_sum(input logic signed [16:0] s);
        logic o;
        o = s[16] != s[15];
        return {o, o ? (s[16] ? 16'h8000 : 16'h7fff) : s[15:0]};
    endfunction

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // front stages
    logic               f_valid;
    logic [1:0]         f_mode;
    logic signed [32:0] f_num_re, f_num_im;
    logic [31:0]        f_den;
    logic signed [16:0] f_sum_re, f_sum_im;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (f_valid),
        .o_mode   (f_mode),
        .o_num_re (f_num_re),
        .o_num_im (f_num_im),
        .o_den    (f_den),
        .o_sum_re (f_sum_re),
        .o_sum_im (f_sum_im)
    );

    // operand preparation
    logic [32:0]      mag_re, mag_im, mr_re, mr_im;
    logic [16:0]      s_re, s_im;
    t_side            n_side;
    logic [NUM_W-1:0] n_num_re, n_num_im;

    always_comb begin
        mag_re = f_num_re[32] ? (~f_num_re + 33'd1) : f_num_re;
        mag_im = f_num_im[32] ? (~f_num_im + 33'd1) : f_num_im;
        mr_re  = (mag_re + HALF) >> FRAC_BITS;
        mr_im  = (mag_im + HALF) >> FRAC_BITS;
        // rounded quotient is floor((2*mag*2^F + d) / 2d)
        n_num_re = (NUM_W'(mag_re[31:0]) << (FRAC_BITS + 1)) + NUM_W'(f_den);
        n_num_im = (NUM_W'(mag_im[31:0]) << (FRAC_BITS + 1)) + NUM_W'(f_den);
        unique case (f_mode) inside
            MODE_ADD, MODE_SUB: begin
                s_re = sat_sum(f_sum_re);
                s_im = sat_sum(f_sum_im);
            end
            MODE_MUL: begin
                s_re = sat_mag(f_num_re[32], NUM_W'(mr_re));
                s_im = sat_mag(f_num_im[32], NUM_W'(mr_im));
            end
            default: begin
                s_re = 17'd0;
                s_im = 17'd0;
            end
        endcase
        n_side.is_div = f_mode == MODE_DIV;
        n_side.dz     = (f_mode == MODE_DIV) && (f_den == 32'd0);
        n_side.neg_re = f_num_re[32];
        n_side.neg_im = f_num_im[32];
        n_side.res_re = s_re[15:0];
        n_side.res_im = s_im[15:0];
        n_side.ovf    = s_re[16] | s_im[16];
    end

    logic             w_valid  [NUM_W+1];
    t_side            w_side   [NUM_W+1];
    logic [32:0]      w_den    [NUM_W+1];
    logic [32:0]      w_rem_re [NUM_W+1];
    logic [32:0]      w_rem_im [NUM_W+1];
    logic [NUM_W-1:0] w_num_re [NUM_W+1];
    logic [NUM_W-1:0] w_num_im [NUM_W+1];
    logic [NUM_W-1:0] w_quo_re [NUM_W+1];
    logic [NUM_W-1:0] w_quo_im [NUM_W+1];

    logic             r_c_valid;
    t_side            r_c_side;
    logic [32:0]      r_c_den;
    logic [NUM_W-1:0] r_c_num_re, r_c_num_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side   <= n_side;
            r_c_den    <= {f_den, 1'b0};
            r_c_num_re <= n_num_re;
            r_c_num_im <= n_num_im;
        end
    end

    assign w_valid[0]  = r_c_valid;
    assign w_side[0]   = r_c_side;
    assign w_den[0]    = r_c_den;
    assign w_rem_re[0] = 33'd0;
    assign w_rem_im[0] = 33'd0;
    assign w_num_re[0] = r_c_num_re;
    assign w_num_im[0] = r_c_num_im;
    assign w_quo_re[0] = '0;
    assign w_quo_im[0] = '0;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        cau_div_cell #(.NUM_W(NUM_W)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (w_valid[g]),
            .i_side   (w_side[g]),
            .i_den    (w_den[g]),
            .i_rem_re (w_rem_re[g]),
            .i_rem_im (w_rem_im[g]),
            .i_num_re (w_num_re[g]),
            .i_num_im (w_num_im[g]),
            .i_quo_re (w_quo_re[g]),
            .i_quo_im (w_quo_im[g]),
            .o_valid  (w_valid[g+1]),
            .o_side   (w_side[g+1]),
            .o_den    (w_den[g+1]),
            .o_rem_re (w_rem_re[g+1]),
            .o_rem_im (w_rem_im[g+1]),
            .o_num_re (w_num_re[g+1]),
            .o_num_im (w_num_im[g+1]),
            .o_quo_re (w_quo_re[g+1]),
            .o_quo_im (w_quo_im[g+1])
        );
    end

    // result selection
    t_side       last_side;
    logic [16:0] q_re, q_im;
    logic [15:0] n_res_re, n_res_im;
    logic        n_ovf, n_dz;

    always_comb begin
        last_side = w_side[NUM_W];
        q_re      = sat_mag(last_side.neg_re, w_quo_re[NUM_W]);
        q_im      = sat_mag(last_side.neg_im, w_quo_im[NUM_W]);
        n_dz      = last_side.dz;
        if (!last_side.is_div) begin
            n_res_re = last_side.res_re;
            n_res_im = last_side.res_im;
            n_ovf    = last_side.ovf;
        end else if (last_side.dz) begin
            n_res_re = 16'd0;
            n_res_im = 16'd0;
            n_ovf    = 1'b0;
        end else begin
            n_res_re = q_re[15:0];
            n_res_im = q_im[15:0];
            n_ovf    = q_re[16] | q_im[16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= w_valid[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res_re         <= n_res_re;
            o_res_im         <= n_res_im;
            o_overflow       <= n_ovf;
            o_divide_by_zero <= n_dz;
        end
    end

endmodule

[rtl/cau_chk.sv]
// port-level checks for the complex arithmetic unit, bound to the top level
module cau_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [1:0]         i_mode,
    input logic signed [15:0] i_a_re,
    input logic signed [15:0] i_a_im,
    input logic signed [15:0] i_b_re,
    input logic signed [15:0] i_b_im,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_res_re,
    input logic signed [15:0] o_res_im,
    input logic               o_overflow,
    input logic               o_divide_by_zero
);

    // a stalled result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_re) && $stable(o_res_im)
            && $stable(o_overflow) && $stable(o_divide_by_zero))
        else $error("stalled result changed");

    // input side only backs up when the output side is blocked
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    // divide by zero gives a clean zero result
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_res_re == 16'sd0 && o_res_im == 16'sd0
            && !o_overflow)
        else $error("divide by zero result not zero");

    // overflow means at least one part sits on a rail
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_res_re == 16'sh7fff || o_res_re == 16'sh8000
            || o_res_im == 16'sh7fff || o_res_im == 16'sh8000)
        else $error("overflow flagged without saturation");

endmodule

bind complex_arithmetic_unit_core cau_chk u_cau_chk (.*);

[verif/cau_checker.sv]
// checker for the complex arithmetic unit: predicts each result and compares it
`timescale 1ns / 1ps

module cau_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_res_re,
    input  logic signed [15:0] i_res_im,
    input  logic               i_overflow,
    input  logic               i_divide_by_zero,
    output int                 o_errors,
    output int                 o_pending
);
    import cau_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        ovf;
        logic        dz;
    } t_cplx_res;

    t_cplx_res exp_results[$];

    assign o_pending = exp_results.size();

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] clamp16(longint v, ref logic ovf);
        if (v > 32767) begin
            ovf = 1'b1;
            return 16'h7fff;
        end
        if (v < -32768) begin
            ovf = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic t_cplx_res compute_complex(logic [1:0] mode, longint ar, longint ai,
                                                 longint br, longint bi);
        t_cplx_res r;
        longint re;
        longint im;
        longint d;
        logic ovf;
        re = 0;
        im = 0;
        ovf = 1'b0;
        r.dz = 1'b0;
        case (mode)
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = round_div(ar * br - ai * bi, longint'(1) << FB);
                im = round_div(ar * bi + ai * br, longint'(1) << FB);
            end
            default: begin
                d = br * br + bi * bi;
                if (d == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = round_div((ar * br + ai * bi) * (longint'(1) << FB), d);
                    im = round_div((ai * br - ar * bi) * (longint'(1) << FB), d);
                end
            end
        endcase
        r.re = clamp16(re, ovf);
        r.im = clamp16(im, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cplx_res e;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_valid && !i_in_stall)
                exp_results.push_back(compute_complex(i_mode, i_a_re, i_a_im, i_b_re, i_b_im));
            if (i_out_valid && !i_out_stall) begin
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result re=%h im=%h", $time, i_res_re, i_res_im);
                    o_errors <= o_errors + 1;
                end else begin
                    e = exp_results.pop_front();
                    if (e.re !== i_res_re || e.im !== i_res_im || e.ovf !== i_overflow
                        || e.dz !== i_divide_by_zero) begin
                        $display({"%0t: mismatch expected re=%h im=%h ovf=%b dz=%b,",
                                  " got re=%h im=%h ovf=%b dz=%b"},
                                 $time, e.re, e.im, e.ovf, e.dz,
                                 i_res_re, i_res_im, i_overflow, i_divide_by_zero);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[verif/tb_complex_arithmetic_unit_core.sv]
// testbench top for the complex arithmetic unit: stimulus and verdict
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_core;
    import cau_pkg::*;

    localparam int LATENCY = FRAC_BITS_DEF + 37;
    localparam int N_RANDOM = 800;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               overflow;
    logic               divide_by_zero;
    int                 errors;
    int                 pending;
    longint             cycles = 0;
    bit                 sending_done;

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    complex_arithmetic_unit_core u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_mode           (mode),
        .i_a_re           (a_re),
        .i_a_im           (a_im),
        .i_b_re           (b_re),
        .i_b_im           (b_im),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_res_re         (res_re),
        .o_res_im         (res_im),
        .o_overflow       (overflow),
        .o_divide_by_zero (divide_by_zero)
    );

    cau_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .i_in_stall       (in_stall),
        .i_mode           (mode),
        .i_a_re           (a_re),
        .i_a_im           (a_im),
        .i_b_re           (b_re),
        .i_b_im           (b_im),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_res_re         (res_re),
        .i_res_im         (res_im),
        .i_overflow       (overflow),
        .i_divide_by_zero (divide_by_zero),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    // operand picker: mostly extremes or small values, some full range
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    // send one operand set and wait for its transfer, after a random gap unless burst is set
    task automatic send_op(logic [1:0] m, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap != 0)
            in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        mode <= m;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        do @(posedge clk); while (in_stall);
        if (!burst)
            in_valid <= 1'b0;
    endtask

    // receiver stall pattern: random waits, with stretches of none
    initial begin
        int wait_cycles;
        out_stall = 1'b1;
        @(posedge clk iff rst_n);
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            out_stall <= (wait_cycles != 0);
            repeat (wait_cycles) @(posedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_complex_arithmetic_unit_core failed");
            $finish;
        end
    end

    initial begin
        bit burst;
        sending_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_ADD;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, zero denominator, saturation
        send_op(MODE_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
        send_op(MODE_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040, 0);
        send_op(MODE_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        send_op(MODE_SUB, 16'h0200, 16'h0100, 16'h0100, 16'h0300, 0);
        send_op(MODE_MUL, 16'h0100, 16'h0200, 16'h0300, 16'hff00, 0);
        send_op(MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_op(MODE_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 0);
        send_op(MODE_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000, 0);
        send_op(MODE_MUL, 16'hffff, 16'h0000, 16'h0080, 16'h0000, 0);
        send_op(MODE_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 0);
        send_op(MODE_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 0);
        send_op(MODE_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 0);
        send_op(MODE_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_op(MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 0);
        send_op(MODE_DIV, 16'h0300, 16'hfd00, 16'h0200, 16'h0000, 0);
        send_op(MODE_DIV, 16'h0001, 16'h0000, 16'h0200, 16'h0000, 0);
        send_op(MODE_DIV, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            burst = ($urandom_range(0, 3) == 0);
            send_op(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand(), burst);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("tb_complex_arithmetic_unit_core passed");
        else
            $display("tb_complex_arithmetic_unit_core failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/complex_arithmetic_unit_core.sv
rtl/cau_chk.sv
verif/cau_checker.sv
verif/tb_complex_arithmetic_unit_core.sv
